// ===== hdl/cpip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex point-in-polygon package
// Shared sizes and operation codes for the point-in-polygon block.
// ----------------------------------------------------------------------------
package cpip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MIN_VERTICES = 3;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEST   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

endpackage

// ===== hdl/convex_point_in_polygon.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex point-in-polygon test
// Stores polygon vertices in a RAM and tests points against the stored edges
// with a cross-product sign walk, one edge per cycle.
// ----------------------------------------------------------------------------
// Channel   Handshake            Fields
// input     start / busy         operation, coord_x, coord_y
// result    res_valid (strobe)   inside_res
//
// Clear, append and unused codes leave busy low.
// A test with fewer than three vertices answers in the next cycle; otherwise
// the walk reads one vertex a cycle from the RAM and ends after the edge to
// the last stored vertex, sooner at a zero or a sign conflict. Each vertex
// passes through the RAM read port and the cross-product stage.
// Reset clears the vertex count; the RAM needs no clearing.
// The result strobe lasts one cycle and cannot be held off.
module convex_point_in_polygon (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          operation,
	input  logic signed [cpip_pkg::COORD_W-1:0] coord_x,
	input  logic signed [cpip_pkg::COORD_W-1:0] coord_y,
	output logic                                res_valid,
	output logic                                inside_res
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q;
	logic [cpip_pkg::CNT_W-1:0]  cnt_q;
	logic [cpip_pkg::CNT_W-1:0]  last_idx;
	logic [cpip_pkg::ADDR_W-1:0] rd_addr_q;
	logic                        issue_q;
	logic                        rv_s1;
	logic [cpip_pkg::ADDR_W-1:0] idx_s1;
	logic                        pv_s2;
	logic                        last_s2;
	logic signed [cpip_pkg::PROD_W-1:0] p1_s2, p2_s2;
	logic signed [cpip_pkg::COORD_W-1:0] px_q, py_q, prev_x_q, prev_y_q;
	logic                        have_first_q, first_neg_q;
	logic                        res_valid_q, inside_q;

	logic                        accept;
	logic                        ram_we, ram_re;
	logic [2*cpip_pkg::COORD_W-1:0] ram_rdata;
	logic signed [cpip_pkg::COORD_W-1:0] cur_x, cur_y;
	logic signed [cpip_pkg::DIFF_W-1:0] ey, dx, ex, dy;
	logic signed [cpip_pkg::CROSS_W-1:0] cross_val;
	logic                        finish;
	logic                        finish_val;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign inside_res = inside_q;
	assign last_idx = cnt_q - cpip_pkg::CNT_W'(1);

	assign ram_we = accept && (operation == cpip_pkg::OP_APPEND)
		&& (cnt_q < cpip_pkg::CNT_W'(cpip_pkg::MAX_VERTICES));
	assign ram_re = (state_q == ST_WALK) && issue_q;

	cpip_ram #(
		.WIDTH(2 * cpip_pkg::COORD_W),
		.DEPTH(cpip_pkg::MAX_VERTICES)
	) u_vertex_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[cpip_pkg::ADDR_W-1:0]),
		.wdata({coord_x, coord_y}),
		.re   (ram_re),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	assign cur_x = ram_rdata[2*cpip_pkg::COORD_W-1:cpip_pkg::COORD_W];
	assign cur_y = ram_rdata[cpip_pkg::COORD_W-1:0];

	assign ey = cpip_pkg::DIFF_W'(py_q) - cpip_pkg::DIFF_W'(prev_y_q);
	assign ex = cpip_pkg::DIFF_W'(px_q) - cpip_pkg::DIFF_W'(prev_x_q);
	assign dx = cpip_pkg::DIFF_W'(cur_x) - cpip_pkg::DIFF_W'(prev_x_q);
	assign dy = cpip_pkg::DIFF_W'(cur_y) - cpip_pkg::DIFF_W'(prev_y_q);

	assign cross_val = cpip_pkg::CROSS_W'(p1_s2) - cpip_pkg::CROSS_W'(p2_s2);

	always_comb begin
		finish = 1'b0;
		finish_val = 1'b1;
		if (pv_s2) begin
			if (cross_val == '0) begin
				finish = 1'b1;
			end else if (have_first_q && (first_neg_q != cross_val[cpip_pkg::CROSS_W-1])) begin
				finish = 1'b1;
				finish_val = 1'b0;
			end else if (last_s2) begin
				finish = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_addr_q <= '0;
			issue_q <= 1'b0;
			rv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
			have_first_q <= 1'b0;
			first_neg_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							cpip_pkg::OP_CLEAR: begin
								cnt_q <= '0;
							end
							cpip_pkg::OP_APPEND: begin
								if (ram_we) begin
									cnt_q <= cnt_q + cpip_pkg::CNT_W'(1);
								end
							end
							cpip_pkg::OP_TEST: begin
								if (cnt_q < cpip_pkg::CNT_W'(cpip_pkg::MIN_VERTICES)) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= ST_WALK;
									rd_addr_q <= '0;
									issue_q <= 1'b1;
									have_first_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					rv_s1 <= ram_re;
					if (ram_re) begin
						if ({1'b0, rd_addr_q} == cpip_pkg::CNT_W'(last_idx)) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + cpip_pkg::ADDR_W'(1);
						end
					end
					pv_s2 <= rv_s1 && (idx_s1 != '0);
					if (pv_s2 && !have_first_q && (cross_val != '0)) begin
						have_first_q <= 1'b1;
						first_neg_q <= cross_val[cpip_pkg::CROSS_W-1];
					end
					if (finish) begin
						state_q <= ST_IDLE;
						issue_q <= 1'b0;
						rv_s1 <= 1'b0;
						pv_s2 <= 1'b0;
						res_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
			inside_q <= 1'b0;
		end
		if (finish) begin
			inside_q <= finish_val;
		end
		if (ram_re) begin
			idx_s1 <= rd_addr_q;
		end
		if (rv_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
			p1_s2 <= ey * dx;
			p2_s2 <= ex * dy;
			last_s2 <= ({1'b0, idx_s1} == cpip_pkg::CNT_W'(last_idx));
		end
	end

endmodule

// ===== hdl/cpip_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cpip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/cpip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon port checker
// Watches the top-level ports for consistent command and result timing.
// ----------------------------------------------------------------------------
module cpip_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   operation,
	input logic                         res_valid
);

	logic test_xfer;
	logic other_xfer;

	assign test_xfer = start && !busy && (operation == cpip_pkg::OP_TEST);
	assign other_xfer = start && !busy && (operation != cpip_pkg::OP_TEST);

	// A test transfer either answers at once or starts a walk.
	a_test_progress: assert property (@(posedge clk) disable iff (!arst_n)
		test_xfer |=> (busy || res_valid))
		else $error("test transfer neither answered nor started a walk");

	// Other operations finish without a result and leave busy low.
	a_other_silent: assert property (@(posedge clk) disable iff (!arst_n)
		other_xfer |=> (!busy && !res_valid))
		else $error("non-test operation produced a result or busy");

	// A result appears only once the block is free again.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy)
		else $error("result strobe while busy");

	// A walk only begins after a test transfer.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(test_xfer))
		else $error("busy rose without a test transfer");

	// A result follows either a test transfer or the end of a walk.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($past(test_xfer) || $past(busy)))
		else $error("result strobe without a cause");

endmodule

bind convex_point_in_polygon cpip_checker u_cpip_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operation(operation),
	.res_valid(res_valid)
);

// ===== tb/cpip_inside_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon result checker
// Watches command and result transfers of the point-in-polygon block, keeps
// its own vertex list and predicts every test answer with a cross-product
// sign walk. Answers are compared in order against the expected queue.
// ----------------------------------------------------------------------------
module cpip_inside_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [1:0]                          operation,
	input  logic signed [cpip_pkg::COORD_W-1:0] coord_x,
	input  logic signed [cpip_pkg::COORD_W-1:0] coord_y,
	input  logic                                res_valid,
	input  logic                                inside_res,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked,
	output int                                  inside_seen
);
	import cpip_pkg::*;

	logic signed [COORD_W-1:0] vx [MAX_VERTICES];
	logic signed [COORD_W-1:0] vy [MAX_VERTICES];
	int                        vcount;
	logic                      inside_due [$];
	logic                      exp_inside;

	function automatic logic inside_by_cross_walk(logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py);
		longint first;
		longint k;
		longint x1;
		longint y1;
		longint x2;
		longint y2;
		int     i;
		first = 0;
		if (vcount < MIN_VERTICES)
			return 1'b0;
		for (i = 0; i + 1 < vcount; i++) begin
			x1 = longint'(vx[i]);
			y1 = longint'(vy[i]);
			x2 = longint'(vx[i + 1]);
			y2 = longint'(vy[i + 1]);
			k = (longint'(py) - y1) * (x2 - x1) - (longint'(px) - x1) * (y2 - y1);
			if (k == 0)
				break;
			if (first == 0)
				first = k;
			else if ((first < 0) != (k < 0))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount = 0;
			inside_due.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			inside_seen = 0;
		end else begin
			if (res_valid) begin
				if (inside_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result transfer, inside_res=%b",
							$realtime, inside_res);
				end else begin
					exp_inside = inside_due.pop_front();
					checked++;
					if (inside_res === 1'b1)
						inside_seen++;
					if (inside_res !== exp_inside) begin
						errors++;
						if (errors <= 10)
							$display("%0t: inside_res mismatch, expected %b, got %b",
								$realtime, exp_inside, inside_res);
					end
				end
			end
			if (start && !busy) begin
				case (op_t'(operation))
					OP_CLEAR: begin
						vcount = 0;
					end
					OP_APPEND: begin
						if (vcount < MAX_VERTICES) begin
							vx[vcount] = coord_x;
							vy[vcount] = coord_y;
							vcount++;
						end
					end
					OP_TEST: begin
						inside_due.push_back(inside_by_cross_walk(coord_x, coord_y));
					end
					default: begin
					end
				endcase
			end
			pending = inside_due.size();
		end
	end

endmodule

// ===== tb/convex_point_in_polygon_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon testbench
// Drives clear, append, test and unused commands into the block: a short directed
// list, then random convex polygons of many sizes probed with points inside,
// outside, on vertices and on edges, mixed with noise and short lists.
// ----------------------------------------------------------------------------
module convex_point_in_polygon_tb;
	import cpip_pkg::*;

	localparam int ITEMS = 1100;
	localparam int QUIET_TAIL = 150;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [1:0]                operation;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic                      res_valid;
	logic                      inside_res;

	int errors;
	int pending;
	int checked;
	int inside_seen;

	int items_sent;
	bit gaps_on;
	int idle_cycles;
	int vxs [$];
	int vys [$];
	int poly_cx;
	int poly_cy;
	int poly_r;

	convex_point_in_polygon u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.res_valid  (res_valid),
		.inside_res (inside_res)
	);

	cpip_inside_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.res_valid   (res_valid),
		.inside_res  (inside_res),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked),
		.inside_seen (inside_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int srand(int lo, int hi);
		return int'($urandom_range(0, hi - lo)) + lo;
	endfunction

	function automatic int clamp16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	task automatic send(op_t op, int x, int y);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				start = 1'b0;
			end
		end
		@(negedge clk);
		operation = op;
		coord_x = x[15:0];
		coord_y = y[15:0];
		start = 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic build_polygon(int n, bit closed, int r);
		real phase;
		real step;
		int  room;
		int  k;
		int  x;
		int  y;
		room = 32767 - r;
		poly_r = r;
		poly_cx = srand(-room, room);
		poly_cy = srand(-room, room);
		phase = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
		step = 2.0 * 3.14159265358979 / n;
		if ($urandom_range(0, 1))
			step = -step;
		vxs.delete();
		vys.delete();
		send(OP_CLEAR, $urandom, $urandom);
		for (k = 0; k < n; k++) begin
			x = clamp16(poly_cx + int'(r * $cos(phase + step * k)));
			y = clamp16(poly_cy + int'(r * $sin(phase + step * k)));
			vxs.push_back(x);
			vys.push_back(y);
			send(OP_APPEND, x, y);
		end
		if (closed)
			send(OP_APPEND, vxs[0], vys[0]);
	endtask

	task automatic probe();
		int span;
		int idx;
		int nx;
		span = poly_r + poly_r / 4 + 1;
		idx = srand(0, vxs.size() - 1);
		nx = (idx + 1) % vxs.size();
		case ($urandom_range(0, 4))
			0: send(OP_TEST, clamp16(poly_cx + srand(-2, 2)), clamp16(poly_cy + srand(-2, 2)));
			1: send(OP_TEST, clamp16(poly_cx + srand(-span, span)),
				clamp16(poly_cy + srand(-span, span)));
			2: send(OP_TEST, vxs[idx], vys[idx]);
			3: send(OP_TEST, (vxs[idx] + vxs[nx]) / 2, (vys[idx] + vys[nx]) / 2);
			default: send(OP_TEST, $urandom, $urandom);
		endcase
	endtask

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || res_valid)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int seq;
		int pick;
		int n;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_CLEAR;
		coord_x = '0;
		coord_y = '0;
		items_sent = 0;
		gaps_on = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty list, short lists, open and closed triangles,
		// a point collinear with the first edge, and full-range corners.
		send(OP_TEST, 5, 5);
		send(OP_NONE, 0, 0);
		send(OP_APPEND, 0, 0);
		send(OP_APPEND, 100, 0);
		send(OP_TEST, 10, 10);
		send(OP_APPEND, 0, 100);
		send(OP_TEST, 10, 10);
		send(OP_TEST, -50, -50);
		send(OP_TEST, 200, 0);
		send(OP_APPEND, 0, 0);
		send(OP_TEST, 60, 60);
		send(OP_TEST, 20, 20);
		send(OP_CLEAR, -1, -1);
		send(OP_TEST, 0, 0);
		send(OP_APPEND, -32768, -32768);
		send(OP_APPEND, 32767, -32768);
		send(OP_APPEND, 32767, 32767);
		send(OP_APPEND, -32768, 32767);
		send(OP_APPEND, -32768, -32768);
		send(OP_TEST, 32767, 32767);
		send(OP_TEST, 0, 0);
		send(OP_TEST, -32768, 0);
		send(OP_NONE, -1, -1);

		seq = 0;
		while (items_sent < ITEMS) begin
			if (items_sent >= ITEMS - QUIET_TAIL)
				gaps_on = 1'b0;
			pick = $urandom_range(0, 9);
			if (seq == 0 || pick <= 6) begin
				if (seq == 0 || $urandom_range(0, 11) == 0)
					n = srand(40, 70);
				else
					n = srand(3, 10);
				case ($urandom_range(0, 2))
					0: r = srand(2, 60);
					1: r = srand(61, 3000);
					default: r = srand(3001, 32000);
				endcase
				build_polygon(n, $urandom_range(0, 1), r);
				repeat (srand(2, 8)) probe();
			end else if (pick == 7) begin
				repeat (srand(1, 6)) send(op_t'($urandom_range(0, 3)), $urandom, $urandom);
			end else if (pick == 8) begin
				send(OP_CLEAR, $urandom, $urandom);
				repeat (srand(0, 2)) send(OP_APPEND, $urandom, $urandom);
				send(OP_TEST, $urandom, $urandom);
			end else begin
				send(OP_CLEAR, $urandom, $urandom);
				send(OP_APPEND, -32768, -32768);
				send(OP_APPEND, 32767, -32768);
				send(OP_APPEND, 32767, 32767);
				send(OP_APPEND, -32768, 32767);
				if ($urandom_range(0, 1))
					send(OP_APPEND, -32768, -32768);
				repeat (srand(1, 4)) send(OP_TEST, $urandom, $urandom);
			end
			seq++;
		end
		@(negedge clk);
		start = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (MAX_VERTICES + 8) @(negedge clk);

		$display("Sent %0d command transfers in %0d random sequences.", items_sent, seq);
		$display("Checked %0d point tests, %0d answered inside.", checked, inside_seen);
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("Failures: %0d, answers still due: %0d.", errors, pending);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
